/* hw/rtl/stick_deadzone_cleaner_top_assert.svh */
`ifndef STICK_DEADZONE_CLEANER_TOP_ASSERT_SVH
`define STICK_DEADZONE_CLEANER_TOP_ASSERT_SVH

// Implication checked in the same cycle, masked while reset is high.
`define SDC_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sdc assertion failed");

// Implication checked in the next cycle, masked while reset is high.
`define SDC_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sdc assertion failed");

// Implication checked in the next cycle, also across reset.
`define SDC_ASSERT_RESET(name, ante, cons) \
   name: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("sdc assertion failed");

`endif

/* hw/rtl/sdc_pkg.sv */
package sdc_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int CORDIC_STEPS_MAX = 24;

   localparam int ONE_Q14    = 16384;
   localparam int ZONE_MAX   = 8192;
   localparam int RAD_MIN_D  = 16;
   localparam int ANG_MIN_D  = 22;
   localparam int DIV_BITS   = 14;
   localparam int DEN_W      = 15;

   localparam logic [29:0] INV_GAIN = 30'd652032874;

   localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS_MAX] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
      32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
      32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   typedef logic signed [15:0] q14_type;
   typedef logic [1:0]         kind_type;

   // How a remapped value is formed once the divider has run.
   localparam kind_type KIND_ZERO = 2'd0;
   localparam kind_type KIND_FULL = 2'd1;
   localparam kind_type KIND_DIV  = 2'd2;
   localparam kind_type KIND_PASS = 2'd3;

   localparam logic [2:0] CSR_INNER    = 3'd0;
   localparam logic [2:0] CSR_OUTER    = 3'd1;
   localparam logic [2:0] CSR_RSMOOTH  = 3'd2;
   localparam logic [2:0] CSR_HZONE    = 3'd3;
   localparam logic [2:0] CSR_VZONE    = 3'd4;
   localparam logic [2:0] CSR_DZONE    = 3'd5;
   localparam logic [2:0] CSR_ASMOOTH  = 3'd6;

   typedef struct packed {
      kind_type    kind;
      logic [14:0] val;
   } rad_side_type;

   typedef struct packed {
      kind_type    kind;
      logic [14:0] val;
      logic [2:0]  prev;
   } ang_side_type;

endpackage

/* hw/rtl/sdc_if.sv */
interface sdc_req_if;
   logic                 valid;
   logic                 ready;
   logic signed [15:0]   x_in;
   logic signed [15:0]   y_in;
   modport source (output valid, x_in, y_in, input ready);
   modport sink (input valid, x_in, y_in, output ready);
endinterface

interface sdc_rsp_if;
   logic                 valid;
   logic                 ready;
   logic signed [15:0]   x_out;
   logic signed [15:0]   y_out;
   modport source (output valid, x_out, y_out, input ready);
   modport sink (input valid, x_out, y_out, output ready);
endinterface

/* hw/rtl/sdc_divider.sv */
module sdc_divider #(
   parameter type side_type = logic
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  logic [sdc_pkg::DEN_W-1:0]       in_num,
   input  logic [sdc_pkg::DEN_W-1:0]       in_den,
   input  side_type                        in_side,
   output logic                            out_valid,
   output logic [sdc_pkg::DIV_BITS-1:0]    out_quo,
   output side_type                        out_side
);
   import sdc_pkg::*;

   // Computes round_half_up(num * 2^14 / den) for num < den, one bit per stage.
   logic [DEN_W-1:0]    rem_ff [0:DIV_BITS];
   logic [DIV_BITS-1:0] low_ff [0:DIV_BITS];
   logic [DEN_W-1:0]    den_ff [0:DIV_BITS];
   logic [DIV_BITS-1:0] quo_ff [0:DIV_BITS];
   side_type            side_ff [0:DIV_BITS];
   logic                val_ff [0:DIV_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff[0] <= 1'b0;
      end else if (en) begin
         val_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= in_num;
         low_ff[0]  <= in_den[DEN_W-1:1];
         den_ff[0]  <= in_den;
         quo_ff[0]  <= '0;
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 0; k < DIV_BITS; k++) begin : g_step
      logic [DEN_W:0]      trial;
      logic [DEN_W-1:0]    rem_in;
      logic [DIV_BITS-1:0] quo_in;

      always_comb begin
         trial = {rem_ff[k], low_ff[k][DIV_BITS-1]};
         if (trial >= {1'b0, den_ff[k]}) begin
            rem_in = DEN_W'(trial - {1'b0, den_ff[k]});
            quo_in = {quo_ff[k][DIV_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[k][DIV_BITS-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[k+1] <= 1'b0;
         end else if (en) begin
            val_ff[k+1] <= val_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= rem_in;
            low_ff[k+1]  <= {low_ff[k][DIV_BITS-2:0], 1'b0};
            den_ff[k+1]  <= den_ff[k];
            quo_ff[k+1]  <= quo_in;
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = val_ff[DIV_BITS];
   assign out_quo   = quo_ff[DIV_BITS];
   assign out_side  = side_ff[DIV_BITS];

endmodule

/* hw/rtl/sdc_cordic_rot.sv */
module sdc_cordic_rot #(
   parameter int STEPS = sdc_pkg::CORDIC_STEPS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [31:0]      in_theta,
   input  logic [14:0]      in_rad,
   output logic             out_valid,
   output sdc_pkg::q14_type out_x,
   output sdc_pkg::q14_type out_y
);
   import sdc_pkg::*;

   localparam int RW = 48;

   logic signed [RW-1:0] x_ff [0:STEPS];
   logic signed [RW-1:0] y_ff [0:STEPS];
   logic signed [32:0]   t_ff [0:STEPS];
   logic                 flip_ff [0:STEPS];
   logic                 val_ff [0:STEPS];
   logic                 oval_ff;
   q14_type              ox_ff;
   q14_type              oy_ff;

   logic signed [32:0] t0;
   logic signed [32:0] t_in;
   logic               flip_in;
   logic [44:0]        x0_mag;

   assign x0_mag = 45'(in_rad) * 45'(INV_GAIN);

   // Fold the angle into the right half plane; the result is negated later.
   always_comb begin
      t0 = {in_theta[31], in_theta};
      if (t0 > 33'sd1073741824) begin
         t_in    = t0 - 33'sd2147483648;
         flip_in = 1'b1;
      end else if (t0 < -33'sd1073741824) begin
         t_in    = t0 + 33'sd2147483648;
         flip_in = 1'b1;
      end else begin
         t_in    = t0;
         flip_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff[0] <= 1'b0;
      end else if (en) begin
         val_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= RW'($signed({1'b0, x0_mag}));
         y_ff[0]    <= '0;
         t_ff[0]    <= t_in;
         flip_ff[0] <= flip_in;
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_iter
      logic signed [RW-1:0] x_in;
      logic signed [RW-1:0] y_in;
      logic signed [32:0]   t_nx;

      always_comb begin
         if (t_ff[k] >= 0) begin
            x_in = x_ff[k] - (y_ff[k] >>> k);
            y_in = y_ff[k] + (x_ff[k] >>> k);
            t_nx = t_ff[k] - $signed({1'b0, ATAN_TURNS[k]});
         end else begin
            x_in = x_ff[k] + (y_ff[k] >>> k);
            y_in = y_ff[k] - (x_ff[k] >>> k);
            t_nx = t_ff[k] + $signed({1'b0, ATAN_TURNS[k]});
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[k+1] <= 1'b0;
         end else if (en) begin
            val_ff[k+1] <= val_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[k+1]    <= x_in;
            y_ff[k+1]    <= y_in;
            t_ff[k+1]    <= t_nx;
            flip_ff[k+1] <= flip_ff[k];
         end
      end
   end

   logic signed [RW-1:0] x_sum;
   logic signed [RW-1:0] y_sum;
   logic signed [17:0]   x_rnd;
   logic signed [17:0]   y_rnd;
   logic signed [17:0]   x_sgn;
   logic signed [17:0]   y_sgn;
   q14_type              x_in_o;
   q14_type              y_in_o;

   always_comb begin
      x_sum = x_ff[STEPS] + RW'(64'sd536870912);
      y_sum = y_ff[STEPS] + RW'(64'sd536870912);
      x_rnd = x_sum[47:30];
      y_rnd = y_sum[47:30];
      x_sgn = flip_ff[STEPS] ? -x_rnd : x_rnd;
      y_sgn = flip_ff[STEPS] ? -y_rnd : y_rnd;
      if (x_sgn > 18'sd16384) begin
         x_in_o = 16'sd16384;
      end else if (x_sgn < -18'sd16384) begin
         x_in_o = -16'sd16384;
      end else begin
         x_in_o = x_sgn[15:0];
      end
      if (y_sgn > 18'sd16384) begin
         y_in_o = 16'sd16384;
      end else if (y_sgn < -18'sd16384) begin
         y_in_o = -16'sd16384;
      end else begin
         y_in_o = y_sgn[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oval_ff <= 1'b0;
      end else if (en) begin
         oval_ff <= val_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ox_ff <= x_in_o;
         oy_ff <= y_in_o;
      end
   end

   assign out_valid = oval_ff;
   assign out_x     = ox_ff;
   assign out_y     = oy_ff;

endmodule

/* hw/rtl/stick_deadzone_cleaner_top.sv */
// Channel   Dir   Payload              Handshake
// req       in    x_in, y_in (Q1.14)   valid / ready
// rsp       out   x_out, y_out (Q1.14) valid / ready
// csr       in    index, data          write enable, no wait
//
// One item per cycle while no result waits at rsp; the path runs through the vectoring CORDIC,
// the 14-stage radix-2 divider and the rotating CORDIC.
// Reset is synchronous; it clears the valid bits and loads the register defaults.
// The whole pipeline holds while a result waits at rsp; req.ready is low only then.
module stick_deadzone_cleaner_top #(
   parameter int CORDIC_STEPS = sdc_pkg::CORDIC_STEPS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   sdc_req_if.sink      req,
   sdc_rsp_if.source    rsp,
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [14:0]  csr_wdata
);
   import sdc_pkg::*;

   localparam int VW = 35;

   // Configuration registers.
   logic [14:0] inner_ff;
   logic [14:0] outer_ff;
   logic        rsmooth_ff;
   logic [13:0] hzone_ff;
   logic [13:0] vzone_ff;
   logic [13:0] dzone_ff;
   logic        asmooth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_ff   <= 15'd3277;
         outer_ff   <= 15'd14746;
         rsmooth_ff <= 1'b1;
         hzone_ff   <= '0;
         vzone_ff   <= '0;
         dzone_ff   <= '0;
         asmooth_ff <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_INNER:   inner_ff   <= csr_wdata;
            CSR_OUTER:   outer_ff   <= csr_wdata;
            CSR_RSMOOTH: rsmooth_ff <= csr_wdata[0];
            CSR_HZONE:   hzone_ff   <= csr_wdata[13:0];
            CSR_VZONE:   vzone_ff   <= csr_wdata[13:0];
            CSR_DZONE:   dzone_ff   <= csr_wdata[13:0];
            CSR_ASMOOTH: asmooth_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic en;
   assign en        = !rsp.valid || rsp.ready;
   assign req.ready = en;

   function automatic logic signed [15:0] clamp_q14(input logic signed [15:0] v);
      if (v > 16'sd16384) begin
         return 16'sd16384;
      end else if (v < -16'sd16384) begin
         return -16'sd16384;
      end
      return v;
   endfunction

   function automatic logic [13:0] zone_pick(input logic [2:0] idx, input logic [13:0] h,
                                             input logic [13:0] v, input logic [13:0] d);
      logic [13:0] z;
      unique case (idx)
         3'd0, 3'd4: z = h;
         3'd2, 3'd6: z = v;
         default:    z = d;
      endcase
      return (z > 14'(ZONE_MAX)) ? 14'(ZONE_MAX) : z;
   endfunction

   // Vectoring CORDIC: stage 0 clamps and folds into the right half plane.
   logic signed [VW-1:0] vx_ff [0:CORDIC_STEPS];
   logic signed [VW-1:0] vy_ff [0:CORDIC_STEPS];
   logic [31:0]          vz_ff [0:CORDIC_STEPS];
   logic                 vval_ff [0:CORDIC_STEPS];

   logic signed [15:0]   xc;
   logic signed [15:0]   yc;
   logic signed [VW-1:0] px0;
   logic signed [VW-1:0] py0;

   always_comb begin
      xc  = clamp_q14(req.x_in);
      yc  = clamp_q14(req.y_in);
      px0 = VW'($signed({xc, 16'b0}));
      py0 = VW'($signed({yc, 16'b0}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vval_ff[0] <= 1'b0;
      end else if (en) begin
         vval_ff[0] <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vx_ff[0] <= (xc < 0) ? -px0 : px0;
         vy_ff[0] <= (xc < 0) ? -py0 : py0;
         vz_ff[0] <= (xc < 0) ? 32'h8000_0000 : 32'h0;
      end
   end

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
      logic signed [VW-1:0] x_in;
      logic signed [VW-1:0] y_in;
      logic [31:0]          z_in;

      always_comb begin
         if (vy_ff[k] > 0) begin
            x_in = vx_ff[k] + (vy_ff[k] >>> k);
            y_in = vy_ff[k] - (vx_ff[k] >>> k);
            z_in = vz_ff[k] + ATAN_TURNS[k];
         end else begin
            x_in = vx_ff[k] - (vy_ff[k] >>> k);
            y_in = vy_ff[k] + (vx_ff[k] >>> k);
            z_in = vz_ff[k] - ATAN_TURNS[k];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vval_ff[k+1] <= 1'b0;
         end else if (en) begin
            vval_ff[k+1] <= vval_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            vx_ff[k+1] <= x_in;
            vy_ff[k+1] <= y_in;
            vz_ff[k+1] <= z_in;
         end
      end
   end

   // Gain correction of the radius and rounding of the angle.
   logic [32:0] px_pos;
   logic [32:0] z_sum;
   logic [62:0] prod_ff;
   logic [15:0] angm_ff;
   logic        mval_ff;

   always_comb begin
      px_pos = vx_ff[CORDIC_STEPS][VW-1] ? 33'd0 : vx_ff[CORDIC_STEPS][32:0];
      z_sum  = {1'b0, vz_ff[CORDIC_STEPS]} + 33'h0_0000_8000;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mval_ff <= 1'b0;
      end else if (en) begin
         mval_ff <= vval_ff[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= px_pos * INV_GAIN;
         angm_ff <= z_sum[31:16];
      end
   end

   logic [62:0] prod_rnd;
   logic [15:0] rad_ff;
   logic [15:0] ang_ff;
   logic        rval_ff;

   assign prod_rnd = prod_ff + 63'(64'd1 << 45);

   always_ff @(posedge clock) begin
      if (reset) begin
         rval_ff <= 1'b0;
      end else if (en) begin
         rval_ff <= mval_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff <= prod_rnd[61:46];
         ang_ff <= angm_ff;
      end
   end

   // Remap set-up: decide each case and prepare the divider operands.
   logic [14:0]        inner_s;
   logic [14:0]        outer_s;
   logic signed [16:0] rad_num;
   logic signed [15:0] rad_dd;
   logic [14:0]        rad_d;
   rad_side_type       rad_side;
   logic [14:0]        rad_dnum;

   logic [2:0]         prev;
   logic [13:0]        arel;
   logic [13:0]        zs;
   logic [13:0]        ze;
   logic [14:0]        aend;
   logic signed [15:0] ang_num;
   logic signed [15:0] ang_dd;
   logic [14:0]        ang_d;
   ang_side_type       ang_side;
   logic [14:0]        ang_dnum;

   always_comb begin
      inner_s = (inner_ff > 15'(ONE_Q14)) ? 15'(ONE_Q14) : inner_ff;
      outer_s = (outer_ff > 15'(ONE_Q14)) ? 15'(ONE_Q14) : outer_ff;
      rad_num = $signed({1'b0, rad_ff}) - $signed({2'b0, inner_s});
      rad_dd  = $signed({1'b0, outer_s}) - $signed({1'b0, inner_s});
      rad_d   = (rad_dd < 16'(RAD_MIN_D)) ? 15'(RAD_MIN_D) : rad_dd[14:0];
      rad_dnum      = '0;
      rad_side.val  = rad_ff[14:0];
      if (rsmooth_ff) begin
         if (rad_num <= 0) begin
            rad_side.kind = KIND_ZERO;
         end else if (rad_num >= $signed({2'b0, rad_d})) begin
            rad_side.kind = KIND_FULL;
         end else begin
            rad_side.kind = KIND_DIV;
            rad_dnum      = rad_num[14:0];
         end
      end else begin
         if (rad_ff < {1'b0, inner_s}) begin
            rad_side.kind = KIND_ZERO;
         end else if (rad_ff > {1'b0, outer_s}) begin
            rad_side.kind = KIND_FULL;
         end else begin
            rad_side.kind = KIND_PASS;
         end
      end

      prev    = ang_ff[15:13];
      arel    = {ang_ff[12:0], 1'b0};
      zs      = zone_pick(prev, hzone_ff, vzone_ff, dzone_ff);
      ze      = zone_pick(3'(prev + 3'd1), hzone_ff, vzone_ff, dzone_ff);
      aend    = 15'(ONE_Q14) - {1'b0, ze};
      ang_num = $signed({2'b0, arel}) - $signed({2'b0, zs});
      ang_dd  = $signed({1'b0, aend}) - $signed({2'b0, zs});
      ang_d   = (ang_dd < 16'(ANG_MIN_D)) ? 15'(ANG_MIN_D) : ang_dd[14:0];
      ang_dnum      = '0;
      ang_side.prev = prev;
      ang_side.val  = {1'b0, arel};
      if (asmooth_ff) begin
         if (ang_num <= 0) begin
            ang_side.kind = KIND_ZERO;
         end else if (ang_num >= $signed({1'b0, ang_d})) begin
            ang_side.kind = KIND_FULL;
         end else begin
            ang_side.kind = KIND_DIV;
            ang_dnum      = ang_num[14:0];
         end
      end else begin
         if (arel < zs) begin
            ang_side.kind = KIND_ZERO;
         end else if ({1'b0, arel} > aend) begin
            ang_side.kind = KIND_FULL;
         end else begin
            ang_side.kind = KIND_PASS;
         end
      end
   end

   logic                rdv_valid;
   logic [DIV_BITS-1:0] rdv_quo;
   rad_side_type        rdv_side;
   logic                adv_valid;
   logic [DIV_BITS-1:0] adv_quo;
   ang_side_type        adv_side;

   sdc_divider #(.side_type(rad_side_type)) u_rad_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rval_ff),
      .in_num    (rad_dnum),
      .in_den    (rad_d),
      .in_side   (rad_side),
      .out_valid (rdv_valid),
      .out_quo   (rdv_quo),
      .out_side  (rdv_side)
   );

   sdc_divider #(.side_type(ang_side_type)) u_ang_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rval_ff),
      .in_num    (ang_dnum),
      .in_den    (ang_d),
      .in_side   (ang_side),
      .out_valid (adv_valid),
      .out_quo   (adv_quo),
      .out_side  (adv_side)
   );

   // Final radius and angle; the angle goes back to 2^32 units per turn.
   logic [14:0] r_fin;
   logic [14:0] a_rel;
   logic [16:0] a2;
   logic [31:0] theta;

   always_comb begin
      unique case (rdv_side.kind)
         KIND_ZERO: r_fin = '0;
         KIND_FULL: r_fin = 15'(ONE_Q14);
         KIND_DIV:  r_fin = {1'b0, rdv_quo};
         default:   r_fin = rdv_side.val;
      endcase
      unique case (adv_side.kind)
         KIND_ZERO: a_rel = '0;
         KIND_FULL: a_rel = 15'(ONE_Q14);
         KIND_DIV:  a_rel = {1'b0, adv_quo};
         default:   a_rel = adv_side.val;
      endcase
      a2    = {adv_side.prev, 14'b0} + {2'b0, a_rel};
      theta = {a2[16:0], 15'b0};
   end

   sdc_cordic_rot #(.STEPS(CORDIC_STEPS)) u_rot (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rdv_valid && adv_valid),
      .in_theta  (theta),
      .in_rad    (r_fin),
      .out_valid (rsp.valid),
      .out_x     (rsp.x_out),
      .out_y     (rsp.y_out)
   );

endmodule

/* hw/rtl/sdc_checker.sv */
module sdc_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input logic [15:0]  rsp_x,
   input logic [15:0]  rsp_y
);
`include "stick_deadzone_cleaner_top_assert.svh"

   logic x_ok;
   logic y_ok;

   assign x_ok = ($signed(rsp_x) <= 16'sd16384) && ($signed(rsp_x) >= -16'sd16384);
   assign y_ok = ($signed(rsp_y) <= 16'sd16384) && ($signed(rsp_y) >= -16'sd16384);

   // The input side only stalls while an item waits at the output.
   `SDC_ASSERT_NOW(a_ready_follows, 1'b1, req_ready == (!rsp_valid || rsp_ready))

   // Results never leave the unit circle box.
   `SDC_ASSERT_NOW(a_range, rsp_valid, x_ok && y_ok)

   // A waiting item keeps its value.
   `SDC_ASSERT_NEXT(a_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_x) && $stable(rsp_y))

   // Nothing comes out right after reset.
   `SDC_ASSERT_RESET(a_reset_empty, reset, !rsp_valid)

endmodule

bind stick_deadzone_cleaner_top sdc_checker u_sdc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_x     (rsp.x_out),
   .rsp_y     (rsp.y_out)
);
